/* rtl/va3_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// va3_pkg
// Types, constants and the arctangent table for the 3D vector angle pipeline.
// ----------------------------------------------------------------------------
package va3_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int CW             = 32;   // maximum coordinate field width
	localparam int NUM_STEPS      = 23;
	localparam int CX_W           = 62;   // CORDIC datapath width (signed), covers the gain
	localparam int Z_W            = 26;   // angle accumulator, signed
	localparam int ANG_W          = 16;
	localparam logic [Z_W-1:0] DEG90_Q16  = Z_W'(5898240);
	localparam logic [Z_W-1:0] DEG180_Q16 = Z_W'(11796480);
	localparam logic [ANG_W-1:0] ANGLE_MAX = ANG_W'(46080);

	typedef struct packed {
		logic signed [CW-1:0] ax;
		logic signed [CW-1:0] ay;
		logic signed [CW-1:0] az;
		logic signed [CW-1:0] bx;
		logic signed [CW-1:0] by;
		logic signed [CW-1:0] bz;
	} in_beat_t;

	typedef struct packed {
		logic [ANG_W-1:0] angle_deg;
		logic             invalid;
	} out_beat_t;

	// Normalized vector pair, 18-bit signed coordinates in [-32768, 32768]
	typedef struct packed {
		logic signed [17:0] ax, ay, az, bx, by, bz;
	} nvec_t;

	// Item flags travelling with the data
	typedef struct packed {
		logic zero_vec;   // either vector zero
		logic dot_neg;
		logic degen;      // X and Y both zero
	} flags_t;

	function automatic logic [Z_W-1:0] atan_q16(input int i);
		logic [Z_W-1:0] r;
		r = '0;
		case (i)
			0:  r = Z_W'(2949120);
			1:  r = Z_W'(1740967);
			2:  r = Z_W'(919879);
			3:  r = Z_W'(466945);
			4:  r = Z_W'(234379);
			5:  r = Z_W'(117304);
			6:  r = Z_W'(58666);
			7:  r = Z_W'(29335);
			8:  r = Z_W'(14668);
			9:  r = Z_W'(7334);
			10: r = Z_W'(3667);
			11: r = Z_W'(1833);
			12: r = Z_W'(917);
			13: r = Z_W'(458);
			14: r = Z_W'(229);
			15: r = Z_W'(115);
			16: r = Z_W'(57);
			17: r = Z_W'(29);
			18: r = Z_W'(14);
			19: r = Z_W'(7);
			20: r = Z_W'(4);
			21: r = Z_W'(2);
			22: r = Z_W'(1);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

/* rtl/va3_norm.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// va3_norm
// Two-stage normalizer: magnitude max and leading-one position, then the
// power-of-two shift that brings the largest magnitude into [16384, 32768].
// ----------------------------------------------------------------------------
module va3_norm #(
	parameter int COORD_BITS = va3_pkg::COORD_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_vld,
	input  va3_pkg::in_beat_t      in_d,
	output logic                   out_vld,
	output va3_pkg::nvec_t         out_d,
	output logic                   out_zero
);
	import va3_pkg::*;

	localparam int MW = COORD_BITS;        // magnitude width holds 2^(CB-1)
	localparam int SW = $clog2(MW + 1);

	logic [5:0][MW-1:0] mag;
	logic [5:0]         neg;
	logic [MW-1:0]      ma, mb;

	logic [5:0][MW-1:0] mag_s1;
	logic [5:0]         neg_s1;
	logic [SW-1:0]      lza_s1, lzb_s1;   // bit index of leading one
	logic               za_s1, zb_s1;
	logic               vld_s1;

	function automatic logic signed [COORD_BITS-1:0] fld(input logic [CW-1:0] r);
		return r[COORD_BITS-1:0];
	endfunction

	function automatic logic [MW-1:0] absv(input logic signed [COORD_BITS-1:0] v);
		logic [MW:0] t;
		t = v[COORD_BITS-1] ? -{v[COORD_BITS-1], v} : {1'b0, v};
		return t[MW-1:0];
	endfunction

	function automatic logic [SW-1:0] msb_pos(input logic [MW-1:0] v);
		logic [SW-1:0] p;
		p = '0;
		for (int i = 0; i < MW; i++)
			if (v[i]) p = SW'(i);
		return p;
	endfunction

	// Shift a magnitude so the max (leading one at p) lands in [2^14, 2^15].
	// A max above 32768 truncates; one that halves down to exactly 32768
	// stops there.
	function automatic logic [17:0] scale(input logic [MW-1:0] v,
		input logic [SW-1:0] p, input logic [MW-1:0] m);
		logic [MW+16:0] w, wm;
		int             sh;
		w  = {17'b0, v};
		wm = {17'b0, m};
		sh = int'(p) - 14;
		if (sh > 0 && (wm >> (sh - 1)) == (MW+17)'(32768))
			sh = sh - 1;
		if (sh > 0)
			w = w >> sh;
		else if (sh < 0)
			w = w << (-sh);
		return w[17:0];
	endfunction

	always_comb begin
		mag[0] = absv(fld(in_d.ax));
		mag[1] = absv(fld(in_d.ay));
		mag[2] = absv(fld(in_d.az));
		mag[3] = absv(fld(in_d.bx));
		mag[4] = absv(fld(in_d.by));
		mag[5] = absv(fld(in_d.bz));
		neg[0] = in_d.ax[COORD_BITS-1];
		neg[1] = in_d.ay[COORD_BITS-1];
		neg[2] = in_d.az[COORD_BITS-1];
		neg[3] = in_d.bx[COORD_BITS-1];
		neg[4] = in_d.by[COORD_BITS-1];
		neg[5] = in_d.bz[COORD_BITS-1];
		ma = mag[0] | mag[1] | mag[2];
		mb = mag[3] | mag[4] | mag[5];
	end

	// max of magnitudes shares the leading-one position of their OR
	logic [MW-1:0] maxa, maxb;
	always_comb begin
		maxa = mag[0];
		if (mag[1] > maxa) maxa = mag[1];
		if (mag[2] > maxa) maxa = mag[2];
		maxb = mag[3];
		if (mag[4] > maxb) maxb = mag[4];
		if (mag[5] > maxb) maxb = mag[5];
	end

	logic [MW-1:0] maxa_s1, maxb_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1  <= mag;
			neg_s1  <= neg;
			lza_s1  <= msb_pos(ma);
			lzb_s1  <= msb_pos(mb);
			za_s1   <= (ma == '0);
			zb_s1   <= (mb == '0);
			maxa_s1 <= maxa;
			maxb_s1 <= maxb;
		end
	end

	nvec_t nv;
	logic [5:0][17:0] sc;
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sc[k]   = scale(mag_s1[k],   lza_s1, maxa_s1);
			sc[k+3] = scale(mag_s1[k+3], lzb_s1, maxb_s1);
		end
		nv.ax = neg_s1[0] ? -$signed(sc[0]) : $signed(sc[0]);
		nv.ay = neg_s1[1] ? -$signed(sc[1]) : $signed(sc[1]);
		nv.az = neg_s1[2] ? -$signed(sc[2]) : $signed(sc[2]);
		nv.bx = neg_s1[3] ? -$signed(sc[3]) : $signed(sc[3]);
		nv.by = neg_s1[4] ? -$signed(sc[4]) : $signed(sc[4]);
		nv.bz = neg_s1[5] ? -$signed(sc[5]) : $signed(sc[5]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (en) begin
			out_vld <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_d    <= nv;
			out_zero <= za_s1 | zb_s1;
		end
	end

endmodule

/* rtl/va3_prod.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// va3_prod
// Products: dot and cross products, sum of squares, then |dot| and an
// exact pipelined integer square root of the cross-product length.
// ----------------------------------------------------------------------------
module va3_prod (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_vld,
	input  va3_pkg::nvec_t         in_d,
	input  logic                   in_zero,
	output logic                   out_vld,
	output logic [33:0]            out_x,    // |dot|, up to 3*2^30
	output logic [32:0]            out_y,    // floor(sqrt(|a x b|^2))
	output va3_pkg::flags_t        out_f
);
	import va3_pkg::*;

	localparam int SQ_W   = 66;
	localparam int ROOT_W = SQ_W / 2;
	localparam int RPS    = 4;                       // root bits per stage
	localparam int NSTG   = (ROOT_W + RPS - 1) / RPS;

	// stage 1: nine products
	logic signed [35:0] p_s1 [9];
	logic               vld_s1, zero_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (en) vld_s1 <= in_vld;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			zero_s1 <= in_zero;
			p_s1[0] <= in_d.ax * in_d.bx;
			p_s1[1] <= in_d.ay * in_d.by;
			p_s1[2] <= in_d.az * in_d.bz;
			p_s1[3] <= in_d.ay * in_d.bz;
			p_s1[4] <= in_d.az * in_d.by;
			p_s1[5] <= in_d.az * in_d.bx;
			p_s1[6] <= in_d.ax * in_d.bz;
			p_s1[7] <= in_d.ax * in_d.by;
			p_s1[8] <= in_d.ay * in_d.bx;
		end
	end

	// stage 2: dot and cross components
	logic signed [37:0] dot_s2, cx_s2, cy_s2, cz_s2;
	logic               vld_s2, zero_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (en) vld_s2 <= vld_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			zero_s2 <= zero_s1;
			dot_s2  <= 38'(p_s1[0]) + 38'(p_s1[1]) + 38'(p_s1[2]);
			cx_s2   <= 38'(p_s1[3]) - 38'(p_s1[4]);
			cy_s2   <= 38'(p_s1[5]) - 38'(p_s1[6]);
			cz_s2   <= 38'(p_s1[7]) - 38'(p_s1[8]);
		end
	end

	// stage 3: squares; each cross magnitude is at most 2^31, so 32x32
	logic [31:0] acx, acy, acz;
	assign acx = cx_s2[37] ? 32'(-cx_s2) : 32'(cx_s2);
	assign acy = cy_s2[37] ? 32'(-cy_s2) : 32'(cy_s2);
	assign acz = cz_s2[37] ? 32'(-cz_s2) : 32'(cz_s2);

	logic [65:0] sqx_s3, sqy_s3, sqz_s3;
	logic [33:0] ax_s3;
	logic        vld_s3, zero_s3, neg_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else if (en) vld_s3 <= vld_s2;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			zero_s3 <= zero_s2;
			neg_s3  <= dot_s2[37];
			ax_s3   <= dot_s2[37] ? 34'(-dot_s2) : 34'(dot_s2);
			sqx_s3  <= 66'(64'(acx) * 64'(acx));
			sqy_s3  <= 66'(64'(acy) * 64'(acy));
			sqz_s3  <= 66'(64'(acz) * 64'(acz));
		end
	end

	// stage 4: sum of squares
	logic [SQ_W-1:0] sq_s4;
	logic [33:0]     ax_s4;
	logic            vld_s4, zero_s4, neg_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else if (en) vld_s4 <= vld_s3;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			zero_s4 <= zero_s3;
			neg_s4  <= neg_s3;
			ax_s4   <= ax_s3;
			sq_s4   <= sqx_s3 + sqy_s3 + sqz_s3;
		end
	end

	// restoring square root, RPS result bits per stage
	logic [SQ_W-1:0]   rem_q  [NSTG+1];
	logic [ROOT_W-1:0] root_q [NSTG+1];
	logic [33:0]       rx_q   [NSTG+1];
	flags_t            rf_q   [NSTG+1];
	logic [NSTG:0]     rv_q;

	assign rem_q[0]  = sq_s4;
	assign root_q[0] = '0;
	assign rx_q[0]   = ax_s4;
	assign rf_q[0]   = '{zero_vec: zero_s4, dot_neg: neg_s4, degen: 1'b0};
	assign rv_q[0]   = vld_s4;

	for (genvar g = 0; g < NSTG; g++) begin : g_root
		logic [SQ_W-1:0]   rem_n;
		logic [ROOT_W-1:0] root_n;
		always_comb begin
			logic [SQ_W+1:0] trial;
			int              b;
			rem_n  = rem_q[g];
			root_n = root_q[g];
			trial  = '0;
			for (int j = 0; j < RPS; j++) begin
				b = ROOT_W - 1 - (g * RPS + j);
				if (b >= 0) begin
					trial = ((SQ_W + 2)'(root_n) << (b + 1)) | ((SQ_W + 2)'(1) << (2 * b));
					if ({2'b0, rem_n} >= trial) begin
						rem_n  = rem_n - trial[SQ_W-1:0];
						root_n = root_n | (ROOT_W'(1) << b);
					end
				end
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) rv_q[g+1] <= 1'b0;
			else if (en) rv_q[g+1] <= rv_q[g];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[g+1]  <= rem_n;
				root_q[g+1] <= root_n;
				rx_q[g+1]   <= rx_q[g];
				rf_q[g+1]   <= rf_q[g];
			end
		end
	end

	always_comb begin
		out_vld     = rv_q[NSTG];
		out_x       = rx_q[NSTG];
		out_y       = root_q[NSTG][32:0];
		out_f       = rf_q[NSTG];
		out_f.degen = (rx_q[NSTG] == '0) && (root_q[NSTG] == '0);
	end

endmodule

/* rtl/va3_cordic.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// va3_cordic
// Pre-scale to 2^57, then one vectoring CORDIC step per stage, quadrant
// fold and rounding to Q8.8 degrees.
// ----------------------------------------------------------------------------
module va3_cordic (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_vld,
	input  logic [33:0]            in_x,
	input  logic [32:0]            in_y,
	input  va3_pkg::flags_t        in_f,
	output logic                   out_vld,
	output va3_pkg::out_beat_t     out_d
);
	import va3_pkg::*;

	localparam int SH_W = 6;

	// pre-scale: shift both left until one reaches bit 57
	logic [33:0]     ormag;
	logic [SH_W-1:0] lead;
	assign ormag = in_x | {1'b0, in_y};
	always_comb begin
		lead = '0;
		for (int i = 0; i < 34; i++)
			if (ormag[i]) lead = SH_W'(i);
	end

	logic signed [CX_W-1:0] x_q [NUM_STEPS+1];
	logic signed [CX_W-1:0] y_q [NUM_STEPS+1];
	logic signed [Z_W-1:0]  z_q [NUM_STEPS+1];
	flags_t                 f_q [NUM_STEPS+1];
	logic [NUM_STEPS:0]     v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q[0] <= 1'b0;
		else if (en) v_q[0] <= in_vld;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			x_q[0] <= CX_W'(in_x) << (SH_W'(57) - lead);
			y_q[0] <= CX_W'(in_y) << (SH_W'(57) - lead);
			z_q[0] <= '0;
			f_q[0] <= in_f;
		end
	end

	for (genvar g = 0; g < NUM_STEPS; g++) begin : g_step
		logic signed [CX_W-1:0] xs, ys;
		assign xs = x_q[g] >>> g;
		assign ys = y_q[g] >>> g;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_q[g+1] <= 1'b0;
			else if (en) v_q[g+1] <= v_q[g];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				f_q[g+1] <= f_q[g];
				if (!y_q[g][CX_W-1]) begin
					x_q[g+1] <= x_q[g] + ys;
					y_q[g+1] <= y_q[g] - xs;
					z_q[g+1] <= z_q[g] + $signed(atan_q16(g));
				end else begin
					x_q[g+1] <= x_q[g] - ys;
					y_q[g+1] <= y_q[g] + xs;
					z_q[g+1] <= z_q[g] - $signed(atan_q16(g));
				end
			end
		end
	end

	// clamp, fold, round
	logic signed [Z_W-1:0] zf;
	logic [Z_W-1:0]        zc, a16, q26;
	flags_t                ff;
	out_beat_t             res;
	always_comb begin
		zf = z_q[NUM_STEPS];
		ff = f_q[NUM_STEPS];
		if (zf < 0)
			zc = '0;
		else if (zf > $signed(DEG90_Q16))
			zc = DEG90_Q16;
		else
			zc = zf;
		a16 = ff.dot_neg ? DEG180_Q16 - zc : zc;
		q26 = (a16 + Z_W'(128)) >> 8;
		res.angle_deg = (q26 > Z_W'(ANGLE_MAX)) ? ANGLE_MAX : q26[ANG_W-1:0];
		res.invalid   = ff.zero_vec;
		if (ff.zero_vec || ff.degen)
			res.angle_deg = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_vld <= 1'b0;
		else if (en) out_vld <= v_q[NUM_STEPS];
	end
	always_ff @(posedge clk) begin
		if (en)
			out_d <= res;
	end

endmodule

/* rtl/vector_angle_3d.sv */
`timescale 1ns / 1ps
// Pipeline: normalize, product, square-root, CORDIC pre-scale and step stages, then
//   the output register. Throughput: one beat per cycle when the output is not stalled;
// the 23-step CORDIC is unrolled, one step a stage.
// A stall at the output holds the whole pipeline; one skid register keeps the
// input ready registered. Reset (arst_n low) clears all valid bits at once.
// ----------------------------------------------------------------------------
// vector_angle_3d
// Angle between two 3D vectors in Q8.8 degrees, via dot product, cross-
// product length and a vectoring CORDIC of atan2(|a x b|, a.b).
// ----------------------------------------------------------------------------
module vector_angle_3d #(
	parameter int COORD_BITS = va3_pkg::COORD_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  va3_pkg::in_beat_t    in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output va3_pkg::out_beat_t   out_data
);
	import va3_pkg::*;

	// Pipeline advances whenever the output register is free or being taken.
	logic en;
	assign en = !out_valid || out_ready;

	// Skid buffer: in_ready is a register; a beat taken while the pipe stalls
	// parks here and enters first once the pipe moves again.
	in_beat_t skid_q;
	logic     skid_vld_q;
	in_beat_t pipe_in;
	logic     pipe_vld;

	assign in_ready = !skid_vld_q;
	assign pipe_in  = skid_vld_q ? skid_q : in_data;
	assign pipe_vld = skid_vld_q || (in_valid && in_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_vld_q <= 1'b0;
		end else if (en) begin
			skid_vld_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!en && in_valid && in_ready)
			skid_q <= in_data;
	end

	// Normalize each vector to a max magnitude in [16384, 32768].
	logic   n_vld, n_zero;
	nvec_t  n_d;
	va3_norm #(.COORD_BITS(COORD_BITS)) u_norm (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_vld(pipe_vld), .in_d(pipe_in),
		.out_vld(n_vld), .out_d(n_d), .out_zero(n_zero)
	);

	// Dot, cross, and the integer root of the cross length.
	logic        p_vld;
	logic [33:0] p_x;
	logic [32:0] p_y;
	flags_t      p_f;
	va3_prod u_prod (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_vld(n_vld), .in_d(n_d), .in_zero(n_zero),
		.out_vld(p_vld), .out_x(p_x), .out_y(p_y), .out_f(p_f)
	);

	// atan2 by CORDIC and the conversion to Q8.8 degrees.
	va3_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_vld(p_vld), .in_x(p_x), .in_y(p_y), .in_f(p_f),
		.out_vld(out_valid), .out_d(out_data)
	);

	// The skid register fills whenever a beat is taken while the pipe stalls.
	a_skid_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(!skid_vld_q && in_valid && !en) |=> skid_vld_q)
		else $error("skid register missed a beat taken during a stall");

	// Results stay in range; an invalid result reads zero.
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.angle_deg <= ANGLE_MAX))
		else $error("angle above 180 degrees");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.invalid) |-> (out_data.angle_deg == '0))
		else $error("invalid result carries a nonzero angle");

	// A stalled output holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
		else $error("output beat changed while stalled");

endmodule
